// ===== design/tea_pkg.sv =====
`timescale 1ns / 1ps

package tea_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CFG_IDX_W   = 2;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t DELTA = 32'h9e3779b9;

    typedef enum logic
    {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        KEY_IDX0 = 2'd0,
        KEY_IDX1 = 2'd1,
        KEY_IDX2 = 2'd2,
        KEY_IDX3 = 2'd3
    } key_idx_t;

    typedef struct packed
    {
        mode_t mode;
        word_t first;
        word_t second;
    } blk_t;

    typedef struct packed
    {
        word_t k0;
        word_t k1;
        word_t k2;
        word_t k3;
    } key_t;

endpackage

// ===== design/tea_front.sv =====
`timescale 1ns / 1ps

module tea_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                command,
    input  tea_pkg::word_t      word_first,
    input  tea_pkg::word_t      word_second,
    output logic                fr_valid,
    output tea_pkg::blk_t       fr_blk,
    input  logic                fr_take
);

    tea_pkg::blk_t                    mem_reg [tea_pkg::QUEUE_DEPTH];
    logic [tea_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [tea_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [tea_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [tea_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [tea_pkg::QCNT_W-1:0]       count_reg;
    logic [tea_pkg::QCNT_W-1:0]       count_next;
    logic                             wr_en;
    logic                             rd_en;
    tea_pkg::blk_t                    wr_blk;

    assign full     = (count_reg == tea_pkg::QCNT_W'(tea_pkg::QUEUE_DEPTH));
    assign fr_valid = (count_reg != '0);
    assign fr_blk   = mem_reg[rd_ptr_reg];
    assign wr_en    = push && !full;
    assign rd_en    = fr_take && fr_valid;

    // classify: decode the command into an operating mode
    always_comb
    begin
        wr_blk.mode   = command ? tea_pkg::MODE_DEC : tea_pkg::MODE_ENC;
        wr_blk.first  = word_first;
        wr_blk.second = word_second;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == tea_pkg::QPTR_W'(tea_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == tea_pkg::QPTR_W'(tea_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_blk;
        end
    end

endmodule

// ===== design/tea_round.sv =====
`timescale 1ns / 1ps

module tea_round
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  tea_pkg::blk_t       in_blk,
    input  tea_pkg::key_t       keys,
    input  tea_pkg::word_t      sum_enc,
    input  tea_pkg::word_t      sum_dec,
    input  logic                half_odd,
    output logic                out_valid,
    output tea_pkg::blk_t       out_blk
);

    function automatic tea_pkg::word_t mix_half
    (
        input tea_pkg::word_t x,
        input tea_pkg::word_t sum,
        input tea_pkg::word_t ka,
        input tea_pkg::word_t kb
    );
        tea_pkg::word_t a;
        tea_pkg::word_t b;
        tea_pkg::word_t c;
        a = (x << 4) + ka;
        b = x + sum;
        c = (x >> 5) + kb;
        return a ^ b ^ c;
    endfunction

    logic             valid_reg;
    tea_pkg::blk_t    blk_reg;
    tea_pkg::blk_t    blk_next;
    logic             dec;
    logic             upd_first;
    tea_pkg::word_t   sum;
    tea_pkg::word_t   other;
    tea_pkg::word_t   target;
    tea_pkg::word_t   ka;
    tea_pkg::word_t   kb;
    tea_pkg::word_t   mix;
    tea_pkg::word_t   res;

    always_comb
    begin
        dec       = (in_blk.mode == tea_pkg::MODE_DEC);
        sum       = dec ? sum_dec : sum_enc;
        // encryption updates the first half on even stages, decryption on odd ones
        upd_first = (half_odd == dec);
        other     = upd_first ? in_blk.second : in_blk.first;
        target    = upd_first ? in_blk.first : in_blk.second;
        ka        = upd_first ? keys.k0 : keys.k2;
        kb        = upd_first ? keys.k1 : keys.k3;
        mix       = mix_half(other, sum, ka, kb);
        res       = dec ? (target - mix) : (target + mix);
        blk_next  = in_blk;
        if (upd_first)
        begin
            blk_next.first = res;
        end
        else
        begin
            blk_next.second = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            blk_reg <= blk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

endmodule

// ===== design/tea_back.sv =====
`timescale 1ns / 1ps

module tea_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tea_pkg::blk_t       in_blk,
    output logic                in_ready,
    input  tea_pkg::key_t       keys,
    output logic                empty,
    input  logic                pop,
    output tea_pkg::word_t      out_first,
    output tea_pkg::word_t      out_second
);

    function automatic tea_pkg::word_t sum_after(input int unsigned n);
        logic [2*tea_pkg::WORD_W-1:0] p;
        p = (2*tea_pkg::WORD_W)'(tea_pkg::DELTA) * (2*tea_pkg::WORD_W)'(n);
        return p[tea_pkg::WORD_W-1:0];
    endfunction

    logic                             stage_valid [tea_pkg::STAGE_COUNT + 1];
    tea_pkg::blk_t                    stage_blk   [tea_pkg::STAGE_COUNT + 1];
    logic                             advance;
    logic                             last_valid;

    tea_pkg::blk_t                    mem_reg [tea_pkg::QUEUE_DEPTH];
    logic [tea_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [tea_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [tea_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [tea_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [tea_pkg::QCNT_W-1:0]       count_reg;
    logic [tea_pkg::QCNT_W-1:0]       count_next;
    logic                             rq_full;
    logic                             wr_en;
    logic                             rd_en;

    assign stage_valid[0] = in_valid;
    assign stage_blk[0]   = in_blk;
    assign last_valid     = stage_valid[tea_pkg::STAGE_COUNT];

    // hold the whole pipe while its last result cannot drain
    assign advance  = !last_valid || !rq_full;
    assign in_ready = advance;

    genvar s;
    generate
        for (s = 0; s < tea_pkg::STAGE_COUNT; s++)
        begin : g_stage
            tea_round u_round
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .in_valid  (stage_valid[s]),
                .in_blk    (stage_blk[s]),
                .keys      (keys),
                .sum_enc   (sum_after(s / 2 + 1)),
                .sum_dec   (sum_after(tea_pkg::ROUND_COUNT - s / 2)),
                .half_odd  (1'((s % 2) == 1)),
                .out_valid (stage_valid[s + 1]),
                .out_blk   (stage_blk[s + 1])
            );
        end
    endgenerate

    assign rq_full    = (count_reg == tea_pkg::QCNT_W'(tea_pkg::QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign wr_en      = last_valid && !rq_full;
    assign rd_en      = pop && !empty;
    assign out_first  = mem_reg[rd_ptr_reg].first;
    assign out_second = mem_reg[rd_ptr_reg].second;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == tea_pkg::QPTR_W'(tea_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == tea_pkg::QPTR_W'(tea_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= stage_blk[tea_pkg::STAGE_COUNT];
        end
    end

endmodule

// ===== design/tea_block_cipher_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake         Payload
// input     push / full       command, word_first, word_second
// result    empty / pop       out_first, out_second
// config    cfg_we            cfg_index, cfg_data (key words 0..3)
//
// One item enters per cycle while the pipe is not held; each item passes through
// the input queue, 64 half-round stages and the result queue.
// The 64-stage half-round pipeline takes new items while earlier ones are in flight.
// rst_n clears queue pointers, pipeline valid bits and the key words.
// When the result queue is full and the last stage holds an item, the whole pipe
// holds; the input queue keeps taking items until it fills.

module tea_block_cipher_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              command,
    input  logic [31:0]                       word_first,
    input  logic [31:0]                       word_second,
    output logic                              empty,
    input  logic                              pop,
    output logic [31:0]                       out_first,
    output logic [31:0]                       out_second,
    input  logic                              cfg_we,
    input  logic [tea_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);

    tea_pkg::key_t    keys_reg;
    tea_pkg::key_t    keys_next;
    logic             fr_valid;
    tea_pkg::blk_t    fr_blk;
    logic             bk_ready;

    always_comb
    begin
        keys_next = keys_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tea_pkg::KEY_IDX0: keys_next.k0 = cfg_data;
                tea_pkg::KEY_IDX1: keys_next.k1 = cfg_data;
                tea_pkg::KEY_IDX2: keys_next.k2 = cfg_data;
                tea_pkg::KEY_IDX3: keys_next.k3 = cfg_data;
                default:           keys_next = keys_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg <= '0;
        end
        else
        begin
            keys_reg <= keys_next;
        end
    end

    tea_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .word_first  (word_first),
        .word_second (word_second),
        .fr_valid    (fr_valid),
        .fr_blk      (fr_blk),
        .fr_take     (bk_ready)
    );

    tea_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (fr_valid),
        .in_blk     (fr_blk),
        .in_ready   (bk_ready),
        .keys       (keys_reg),
        .empty      (empty),
        .pop        (pop),
        .out_first  (out_first),
        .out_second (out_second)
    );

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> fr_valid)
        else $error("accepted item missing from input queue");

    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid && !bk_ready |=> fr_valid && $stable(fr_blk))
        else $error("input queue head changed while pipeline held");

    a_key2_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == tea_pkg::KEY_IDX2 |=> keys_reg.k2 == $past(cfg_data))
        else $error("key word 2 write lost");

    a_key_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> keys_reg == $past(keys_reg))
        else $error("key changed without a write");

endmodule
